// ===== design/chacc_pkg.sv =====
// Package for the channel hit accumulator: widths, stream packing, state enum
// and the request structure between the top level and the slot store.
// No dependencies.
`default_nettype none

package chacc_pkg;

	localparam int CHANNELS   = 1024;
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int SLOT_W     = CH_W;
	localparam int CNT_W      = $clog2(CHANNELS + 1);
	localparam int E_W        = 32;
	localparam int T_W        = 32;

	// slave tdata: channel_id, energy, hit_time
	localparam int IN_BITS    = CH_W + E_W + T_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	// master tdata: slot, is_new, energy_total, first_time, hit_count
	localparam int OUT_BITS    = SLOT_W + 1 + E_W + T_W + CNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic FUNC_DEPOSIT = 1'b0;
	localparam logic FUNC_END     = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_SLOT
	} state_t;

	// one hit slot: owning channel, accumulated energy, first time
	typedef struct packed {
		logic [CH_W-1:0] chan;
		logic [E_W-1:0]  energy;
		logic [T_W-1:0]  first_time;
	} slot_word_t;

	typedef struct packed {
		logic              map_re;
		logic [CH_W-1:0]   map_raddr;
		logic              map_we;
		logic [CH_W-1:0]   map_waddr;
		logic [SLOT_W-1:0] map_wdata;
		logic              slot_re;
		logic [SLOT_W-1:0] slot_raddr;
		logic              slot_we;
		logic [SLOT_W-1:0] slot_waddr;
		slot_word_t        slot_wdata;
	} store_req_t;

	function automatic logic [E_W-1:0] sat_add(input logic [E_W-1:0] a,
	                                            input logic [E_W-1:0] b);
		logic [E_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[E_W]) begin
			return {E_W{1'b1}};
		end
		return s[E_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/chacc_store.sv =====
// Slot store: channel-to-slot map and per-slot word, both synchronous
// memories with registered read data. Uses chacc_pkg.
`default_nettype none

module chacc_store import chacc_pkg::*; (
	input  wire logic       clk,
	input  wire store_req_t req,
	output logic [SLOT_W-1:0] map_rdata,
	output slot_word_t        slot_rdata
);

	logic [SLOT_W-1:0] map_mem [CHANNELS];
	slot_word_t        slot_mem [CHANNELS];
	logic [SLOT_W-1:0] map_rd_q;
	slot_word_t        slot_rd_q;

	// map: write port plus read port with write-to-read bypass
	always_ff @(posedge clk) begin
		if (req.map_we) begin
			map_mem[req.map_waddr] <= req.map_wdata;
		end
		if (req.map_re) begin
			if (req.map_we && req.map_waddr == req.map_raddr) begin
				map_rd_q <= req.map_wdata;
			end else begin
				map_rd_q <= map_mem[req.map_raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			slot_mem[req.slot_waddr] <= req.slot_wdata;
		end
		if (req.slot_re) begin
			slot_rd_q <= slot_mem[req.slot_raddr];
		end
	end

	assign map_rdata  = map_rd_q;
	assign slot_rdata = slot_rd_q;

endmodule

`default_nettype wire

// ===== design/channel_hit_accumulator_unit.sv =====
// Top level of the channel hit accumulator: stream handshake, sequencer,
// hit counter and result register. Uses chacc_pkg and chacc_store.
`default_nettype none

// Usage
// - Slave stream (s_*): one transfer per item. s_tuser is func (0 deposit,
//   1 end of event); s_tdata carries channel_id, energy and hit_time.
// - Master stream (m_*): exactly one result transfer per input item, in order.
// - A deposit reads the channel map, then the slot word addressed by it, then
//   writes back. A channel counts as mapped only when its stored slot lies
//   below the hit count and that slot names the channel back, so stale map
//   entries need no clearing: no sweep after reset and the end of event is a
//   single step that zeroes the hit count.
// - An item goes through ST_MAP and ST_SLOT; its result is registered once
//   the output register is free. Items do not overlap, because of the two
//   dependent memory reads (map, then slot word); the next item is taken in
//   the cycle its predecessor writes back, with a bypass on the map read port.
// - Reset: the hit count and control clear at once; the block is ready in
//   the first cycle after arst_n rises.
// - Stall: a result waits in the output register; one more item is read up
//   to its slot word and holds there until the register frees.

module channel_hit_accumulator_unit import chacc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [9:0] channel_id, [41:10] energy, [73:42] hit_time, rest zero
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] func
	input  wire logic                   s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [9:0] slot, [10] is_new, [42:11] energy_total, [74:43] first_time,
	// [85:75] hit_count, rest zero
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	state_t state_q, state_d;

	logic              func_q;
	logic [CH_W-1:0]   ch_q;
	logic [E_W-1:0]    energy_q;
	logic [T_W-1:0]    time_q;
	logic [CNT_W-1:0]  hits_q, hits_d;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	store_req_t        req;
	logic [SLOT_W-1:0] map_rdata;
	slot_word_t        slot_rdata;

	logic in_xfer, out_free, finish, mapped;
	logic [CH_W-1:0] in_ch;

	// result fields
	logic [SLOT_W-1:0] r_slot;
	logic              r_new;
	logic [E_W-1:0]    r_energy;
	logic [T_W-1:0]    r_time;

	assign in_ch    = s_tdata[CH_W-1:0];
	assign out_free = !m_valid_q || m_tready;
	assign finish   = (state_q == ST_SLOT) && out_free;
	assign s_tready = (state_q == ST_IDLE) || finish;
	assign in_xfer  = s_tvalid && s_tready;

	chacc_store u_store (
		.clk       (clk),
		.req       (req),
		.map_rdata (map_rdata),
		.slot_rdata(slot_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				state_d = ST_SLOT;
			end
			ST_SLOT: begin
				if (finish) begin
					state_d = in_xfer ? ST_MAP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hit test: the slot must be live in this event and point back at us
	always_comb begin
		mapped = 1'b0;
		if ({1'b0, map_rdata} < hits_q) begin
			if (slot_rdata.chan == ch_q) begin
				mapped = 1'b1;
			end
		end
	end

	// outputs: memory requests and result
	always_comb begin
		req            = '0;
		req.map_re     = in_xfer;
		req.map_raddr  = in_ch;
		req.map_waddr  = ch_q;
		req.map_wdata  = hits_q[SLOT_W-1:0];
		req.slot_re    = (state_q == ST_MAP);
		req.slot_raddr = map_rdata;
		hits_d   = hits_q;
		r_slot   = '0;
		r_new    = 1'b0;
		r_energy = '0;
		r_time   = '0;
		case (state_q)
			ST_SLOT: begin
				if (func_q == FUNC_END) begin
					if (finish) begin
						hits_d = '0;
					end
				end else if (mapped) begin
					r_slot   = map_rdata;
					r_energy = sat_add(slot_rdata.energy, energy_q);
					r_time   = slot_rdata.first_time;
					req.slot_we    = finish;
					req.slot_waddr = map_rdata;
					req.slot_wdata = '{chan: slot_rdata.chan, energy: r_energy,
					                   first_time: slot_rdata.first_time};
				end else begin
					r_slot   = hits_q[SLOT_W-1:0];
					r_new    = 1'b1;
					r_energy = energy_q;
					r_time   = time_q;
					req.map_we     = finish;
					req.slot_we    = finish;
					req.slot_waddr = hits_q[SLOT_W-1:0];
					req.slot_wdata = '{chan: ch_q, energy: energy_q,
					                   first_time: time_q};
					if (finish) begin
						hits_d = hits_q + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hits_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hits_q  <= hits_d;
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q   <= s_tuser;
			ch_q     <= in_ch;
			energy_q <= s_tdata[CH_W +: E_W];
			time_q   <= s_tdata[CH_W+E_W +: T_W];
		end
	end

	// result register; end item reports the count before the clear
	always_ff @(posedge clk) begin
		if (finish) begin
			m_data_q <= OUT_TDATA_W'({hits_d | ((func_q == FUNC_END) ? hits_q : '0),
			                          r_time, r_energy, r_new, r_slot});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== bench/channel_hit_accumulator_unit_tb.sv =====
// Self-checking testbench for channel_hit_accumulator_unit: drives deposit and
// end-of-event transfers, predicts each result and checks it field by field.
// Depends on chacc_pkg and the design sources; needs nothing else.
`default_nettype none

module channel_hit_accumulator_unit_tb;
	import chacc_pkg::*;

	// bit offsets of the result fields in m_tdata, lowest first
	localparam int OFF_NEW   = SLOT_W;
	localparam int OFF_TOTAL = SLOT_W + 1;
	localparam int OFF_FIRST = OFF_TOTAL + E_W;
	localparam int OFF_COUNT = OFF_FIRST + T_W;

	localparam int SMALL_PHASE_ITEMS = 150;
	localparam int DRAIN_LIMIT       = 2000;
	localparam int SETTLE_CYCLES     = 10;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic              is_new;
		logic [E_W-1:0]    energy_total;
		logic [T_W-1:0]    first_time;
		logic [CNT_W-1:0]  hit_count;
	} hit_result_t;

	// Hit table predictor and store of expected results.
	class hit_accumulator_model;
		bit                mapped[CHANNELS];
		logic [SLOT_W-1:0] chan_slot[CHANNELS];
		logic [CH_W-1:0]   slot_chan[CHANNELS];
		logic [E_W-1:0]    slot_energy[CHANNELS];
		logic [T_W-1:0]    slot_time[CHANNELS];
		int unsigned       hits;
		hit_result_t       expected_results[$];
		int unsigned       errors;
		int unsigned       deposits;
		int unsigned       event_ends;
		int unsigned       saturations;
		int unsigned       results_seen;
		int unsigned       widest_event;

		function new();
			hits = 0;
			errors = 0;
			deposits = 0;
			event_ends = 0;
			saturations = 0;
			results_seen = 0;
			widest_event = 0;
		endfunction

		// accepted input: update the table and queue the expected result
		function void note_item(logic func, logic [CH_W-1:0] ch, logic [E_W-1:0] e,
				logic [T_W-1:0] t);
			hit_result_t  r;
			logic [E_W:0] sum;
			logic [SLOT_W-1:0] s;
			r.slot = '0;
			r.is_new = 1'b0;
			r.energy_total = '0;
			r.first_time = '0;
			if (func == FUNC_END) begin
				r.hit_count = hits[CNT_W-1:0];
				for (int i = 0; i < hits; i++) begin
					mapped[slot_chan[i]] = 1'b0;
				end
				if (hits > widest_event) begin
					widest_event = hits;
				end
				hits = 0;
				event_ends++;
			end else begin
				deposits++;
				if (!mapped[ch]) begin
					s = hits[SLOT_W-1:0];
					mapped[ch] = 1'b1;
					chan_slot[ch] = s;
					slot_chan[s] = ch;
					slot_energy[s] = e;
					slot_time[s] = t;
					hits++;
					r.is_new = 1'b1;
				end else begin
					s = chan_slot[ch];
					sum = {1'b0, slot_energy[s]} + {1'b0, e};
					if (sum[E_W]) begin
						slot_energy[s] = '1;
						saturations++;
					end else begin
						slot_energy[s] = sum[E_W-1:0];
					end
				end
				r.slot = s;
				r.energy_total = slot_energy[s];
				r.first_time = slot_time[s];
				r.hit_count = hits[CNT_W-1:0];
			end
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// accepted result: compare with the oldest expectation
		function void check_result(logic [OUT_TDATA_W-1:0] word);
			hit_result_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0h", $time, word);
				return;
			end
			want = expected_results.pop_front();
			compare_field("slot", 32'(want.slot), 32'(word[SLOT_W-1:0]));
			compare_field("is_new", 32'(want.is_new), 32'(word[OFF_NEW]));
			compare_field("energy_total", want.energy_total, word[OFF_TOTAL +: E_W]);
			compare_field("first_time", want.first_time, word[OFF_FIRST +: T_W]);
			compare_field("hit_count", 32'(want.hit_count), 32'(word[OFF_COUNT +: CNT_W]));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	hit_accumulator_model hit_model;
	bit                   idle_on;

	channel_hit_accumulator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	// Monitor: inputs and outputs are sampled at the edge, before any update.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			hit_model.note_item(s_tuser, s_tdata[CH_W-1:0], s_tdata[CH_W +: E_W],
				s_tdata[CH_W+E_W +: T_W]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			hit_model.check_result(m_tdata);
		end
	end

	// Receiver: runs of ready broken by random stall bursts while idling is on.
	initial begin
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (idle_on && $urandom_range(0, 1) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	end

	// One transfer on the slave side; valid stays high between back-to-back items.
	task automatic send_item(input logic func, input logic [CH_W-1:0] ch,
			input logic [E_W-1:0] e, input logic [T_W-1:0] t);
		logic [IN_TDATA_W-1:0] word;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		word = '0;
		word[CH_W-1:0] = ch;
		word[CH_W +: E_W] = e;
		word[CH_W+E_W +: T_W] = t;
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic deposit(input logic [CH_W-1:0] ch, input logic [E_W-1:0] e,
			input logic [T_W-1:0] t);
		send_item(FUNC_DEPOSIT, ch, e, t);
	endtask

	// end-of-event transfer; data bits are don't-care, so fill them randomly
	task automatic end_event();
		send_item(FUNC_END, CH_W'($urandom), $urandom, $urandom);
	endtask

	// mix of large, mid and tiny energies so both accumulation and saturation show
	function automatic logic [E_W-1:0] pick_energy();
		case ($urandom_range(0, 3))
			0: begin
				return $urandom;
			end
			1: begin
				return $urandom_range(0, 255);
			end
			default: begin
				return $urandom_range(0, 32'h3fff_ffff);
			end
		endcase
	endfunction

	// Events of a few deposits over a narrow channel window, so repeats are common;
	// a share of empty events and back-to-back ends as noise.
	task automatic run_small_events();
		int unsigned sent;
		int unsigned len;
		int unsigned base;
		int unsigned span;
		sent = 0;
		while (sent < SMALL_PHASE_ITEMS) begin
			len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
			span = $urandom_range(0, 15);
			base = $urandom_range(0, CHANNELS - 1 - span);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					deposit(CH_W'($urandom), pick_energy(), $urandom);
				end else begin
					deposit(CH_W'($urandom_range(base, base + span)), pick_energy(), $urandom);
				end
			end
			end_event();
			sent += len + 1;
		end
	endtask

	// One event that maps every channel in shuffled order, with repeat deposits
	// mixed in; idling stops for the closing part of the run.
	task automatic run_full_event();
		logic [CH_W-1:0] order[CHANNELS];
		logic [CH_W-1:0] tmp;
		int unsigned     j;
		for (int i = 0; i < CHANNELS; i++) begin
			order[i] = CH_W'(i);
		end
		for (int i = CHANNELS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int k = 0; k < CHANNELS; k++) begin
			if (k >= 800) begin
				idle_on = 1'b0;
			end
			if (k > 0 && $urandom_range(0, 7) == 0) begin
				deposit(order[$urandom_range(0, k - 1)], pick_energy(), $urandom);
			end
			deposit(order[k], pick_energy(), $urandom);
		end
		end_event();
	endtask

	initial begin
		int unsigned drain;
		hit_model = new();
		idle_on = 1'b1;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= FUNC_DEPOSIT;
		s_tdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty event, field extremes, saturation, reuse after clear
		end_event();
		deposit(CH_W'(0), 32'h0000_0000, 32'h0000_0000);
		deposit(CH_W'(CHANNELS - 1), 32'hffff_ffff, 32'hffff_ffff);
		deposit(CH_W'(CHANNELS - 1), 32'h0000_0001, 32'h1234_5678);
		deposit(CH_W'(0), 32'hffff_ffff, 32'h0000_0001);
		deposit(CH_W'(0), 32'hffff_ffff, 32'h0000_0002);
		deposit(10'h155, 32'h5555_5555, 32'haaaa_aaaa);
		deposit(10'h2aa, 32'haaaa_aaaa, 32'h5555_5555);
		deposit(10'h155, 32'haaaa_aaaa, 32'h0000_0000);
		deposit(10'h155, 32'h0000_0000, 32'hffff_ffff);
		deposit(10'h2aa, 32'h5555_5556, 32'h0000_0003);
		end_event();
		end_event();
		deposit(CH_W'(CHANNELS - 1), 32'h0000_0010, 32'h8000_0000);
		deposit(CH_W'(0), 32'h8000_0000, 32'h7fff_ffff);
		deposit(CH_W'(CHANNELS - 1), 32'h0000_0020, 32'h0000_0000);
		deposit(CH_W'(0), 32'h8000_0000, 32'h0000_0000);
		end_event();

		run_small_events();
		run_full_event();
		s_tvalid <= 1'b0;

		drain = 0;
		while (hit_model.expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (hit_model.expected_results.size() != 0) begin
			hit_model.errors++;
			$display("%0t: results missing, expected %0d more, actual 0",
				$time, hit_model.expected_results.size());
		end

		$display("Covered %0d deposits and %0d event ends, %0d saturating additions;",
			hit_model.deposits, hit_model.event_ends, hit_model.saturations);
		$display("widest event held %0d hits, %0d results checked, %0d errors.",
			hit_model.widest_event, hit_model.results_seen, hit_model.errors);
		if (hit_model.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
design/chacc_pkg.sv
design/chacc_store.sv
design/channel_hit_accumulator_unit.sv
bench/channel_hit_accumulator_unit_tb.sv
